// ----- rtl/core/ssnt_pkg.sv -----
package ssnt_pkg;

  localparam int Capacity = 32;
  localparam int KeyBits = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int ScoreW = 17;
  localparam int OpW = 3;
  localparam int KeyPortW = 32;
  localparam int CountW = 6;
  localparam int StatusW = 2;

  localparam logic [OpW-1:0] OP_UPSERT = 3'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd1;
  localparam logic [OpW-1:0] OP_SUFFIX = 3'd2;
  localparam logic [OpW-1:0] OP_HEAVY = 3'd3;
  localparam logic [OpW-1:0] OP_LOOKUP = 3'd4;

  localparam logic [StatusW-1:0] ST_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL = 2'd1;
  localparam logic [StatusW-1:0] ST_ABSENT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DELSHIFT,
    S_INSFIND,
    S_INSSHIFT,
    S_INSWRITE,
    S_SUFFIND,
    S_SUFEMIT,
    S_HEAVYRD,
    S_HEAVYCMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture command fields, clear scan pointer
    logic scan_rst;   // pointer back to zero
    logic scan_inc;   // pointer up one
    logic scan_dec;   // pointer down one
    logic set_ptr_top;// pointer to count
    logic ins_mark;   // remember pointer as insert position
    logic shift_down; // copy entry ptr+1 to ptr
    logic shift_up;   // copy entry ptr-1 to ptr
    logic write_new;  // write new pair at ptr
    logic cnt_inc;
    logic cnt_dec;
    logic heavy_rd;   // point at heavy index
    logic emit;
    logic [StatusW-1:0] emit_status;
    logic emit_entry;
    logic emit_score;
    logic emit_heavy;
    logic emit_empty;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic at_end;     // ptr >= count
    logic key_hit;    // entry at ptr has the command key
    logic score_lt;   // entry score below command score
    logic thr_lt;     // entry score below threshold
    logic full;
    logic ptr_zero;
    logic ptr_last;   // ptr + 1 == count
    logic at_ins;     // ptr at the insert position
    logic heavy_ok;   // heavy index in range
  } stat_t;

endpackage

// ----- rtl/core/ssnt_ram.sv -----
module ssnt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ssnt_datapath.sv -----
module ssnt_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ssnt_pkg::cmd_t                 cmd,
  output ssnt_pkg::stat_t                stat,
  input  logic [ssnt_pkg::OpW-1:0]       opcode,
  input  logic [ssnt_pkg::KeyPortW-1:0]  key,
  input  logic [ssnt_pkg::ScoreW-1:0]    score,
  input  logic [ssnt_pkg::ScoreW-1:0]    threshold,
  output logic [ssnt_pkg::KeyPortW-1:0]  out_key,
  output logic [ssnt_pkg::ScoreW-1:0]    out_score,
  output logic [ssnt_pkg::StatusW-1:0]   status,
  output logic                           heavy,
  output logic [ssnt_pkg::CountW-1:0]    count,
  output logic                           empty_run,
  output logic                           last,
  output logic                           valid
);

  localparam int IW = ssnt_pkg::IdxW;
  localparam int CW = ssnt_pkg::CntW;
  localparam int KW = ssnt_pkg::KeyBits;
  localparam int SW = ssnt_pkg::ScoreW;
  localparam int PW = SW + CW;

  logic [ssnt_pkg::OpW-1:0] op;
  logic [KW-1:0] ckey;
  logic [SW-1:0] cscore, cthr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ins_pos;
  logic [PW-1:0] hprod;
  logic [CW:0]   hidx;
  logic          hok;

  // ram ports
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [KW-1:0] wkey, rkey;
  logic [SW-1:0] wscore, rscore;
  logic [CW-1:0] ptr_next;

  // table count after this cycle
  always_comb begin
    cnt_next = cnt;
    if (cmd.cnt_inc) cnt_next = cnt + CW'(1);
    else if (cmd.cnt_dec) cnt_next = cnt - CW'(1);
  end

  // hold command fields and table count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    if (cmd.load) begin
      op     <= opcode;
      ckey   <= key[KW-1:0];
      cscore <= score;
      cthr   <= threshold;
      hprod  <= PW'(threshold) * PW'(cnt);
    end
  end

  // ceil of threshold*count/65536, registered
  always_ff @(posedge clk) begin
    hidx <= (CW+1)'((hprod + PW'(16'hFFFF)) >> 16);
  end
  assign hok = (cnt != '0) && (hidx != '0) && ((hidx - (CW+1)'(1)) < (CW+1)'(cnt));

  // advance scan pointer
  always_comb begin
    ptr_next = ptr;
    priority if (cmd.load || cmd.scan_rst) ptr_next = '0;
    else if (cmd.set_ptr_top) ptr_next = cnt;
    else if (cmd.heavy_rd) ptr_next = CW'(hidx - (CW+1)'(1));
    else if (cmd.scan_inc) ptr_next = ptr + CW'(1);
    else if (cmd.scan_dec) ptr_next = ptr - CW'(1);
    else ptr_next = ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) ptr <= '0;
    else     ptr <= ptr_next;
  end

  // hold insert position for the upward shift
  always_ff @(posedge clk) begin
    if (rst) ins_pos <= '0;
    else if (cmd.ins_mark) ins_pos <= ptr;
  end

  // read lookahead: shifts read the neighbor of the next pointer
  always_comb begin
    raddr = ptr_next[IW-1:0];
    if (cmd.shift_down) raddr = IW'(ptr_next + CW'(1));
    else if (cmd.scan_dec && cmd.shift_up) raddr = IW'(ptr - CW'(2));
    else if (cmd.set_ptr_top) raddr = IW'(cnt - CW'(1));
  end

  // write path
  always_comb begin
    we     = cmd.shift_down || cmd.shift_up || cmd.write_new;
    waddr  = ptr[IW-1:0];
    wkey   = rkey;
    wscore = rscore;
    if (cmd.write_new) begin
      wkey   = ckey;
      wscore = cscore;
    end
  end

  ssnt_ram #(.Width(KW), .Depth(ssnt_pkg::Capacity)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rkey)
  );
  ssnt_ram #(.Width(SW), .Depth(ssnt_pkg::Capacity)) u_scores (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wscore), .raddr(raddr), .rdata(rscore)
  );

  // status back to the controller
  always_comb begin
    stat.op       = op;
    stat.at_end   = ptr >= cnt;
    stat.key_hit  = rkey == ckey;
    stat.score_lt = rscore < cscore;
    stat.thr_lt   = rscore < cthr;
    stat.full     = cnt >= CW'(ssnt_pkg::Capacity);
    stat.ptr_zero = ptr == '0;
    stat.ptr_last = (ptr + CW'(1)) == cnt;
    stat.at_ins   = ptr == ins_pos;
    stat.heavy_ok = hok;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_key   <= cmd.emit_entry ? ssnt_pkg::KeyPortW'(rkey) : '0;
      out_score <= (cmd.emit_entry || cmd.emit_score) ? rscore : '0;
      status    <= cmd.emit_status;
      heavy     <= cmd.emit_heavy;
      empty_run <= cmd.emit_empty;
      last      <= cmd.emit_last;
      count     <= ssnt_pkg::CountW'(cnt_next);
    end
  end

endmodule

// ----- rtl/core/ssnt_ctrl.sv -----
module ssnt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ssnt_pkg::stat_t stat,
  output ssnt_pkg::cmd_t  cmd
);

  ssnt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ssnt_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state; the read data of the pointer is valid in every scan state
  always_comb begin
    state_next = state;
    unique case (state)
      ssnt_pkg::S_IDLE: if (start) state_next = ssnt_pkg::S_DONE;
      ssnt_pkg::S_DONE: begin
        unique case (stat.op)
          ssnt_pkg::OP_UPSERT, ssnt_pkg::OP_REMOVE, ssnt_pkg::OP_LOOKUP:
            state_next = ssnt_pkg::S_FIND;
          ssnt_pkg::OP_SUFFIX: state_next = ssnt_pkg::S_SUFFIND;
          ssnt_pkg::OP_HEAVY:  state_next = ssnt_pkg::S_HEAVYRD;
          default:             state_next = ssnt_pkg::S_IDLE;
        endcase
      end
      ssnt_pkg::S_FIND: begin
        priority if (stat.at_end) begin
          if (stat.op == ssnt_pkg::OP_UPSERT && !stat.full) state_next = ssnt_pkg::S_INSFIND;
          else state_next = ssnt_pkg::S_IDLE;
        end else if (stat.key_hit) begin
          if (stat.op == ssnt_pkg::OP_LOOKUP) state_next = ssnt_pkg::S_IDLE;
          else if (stat.ptr_last) begin
            if (stat.op == ssnt_pkg::OP_UPSERT) state_next = ssnt_pkg::S_INSFIND;
            else state_next = ssnt_pkg::S_IDLE;
          end else state_next = ssnt_pkg::S_DELSHIFT;
        end else begin
          state_next = ssnt_pkg::S_FIND;
        end
      end
      ssnt_pkg::S_DELSHIFT: begin
        if (stat.ptr_last) begin
          if (stat.op == ssnt_pkg::OP_UPSERT) state_next = ssnt_pkg::S_INSFIND;
          else state_next = ssnt_pkg::S_IDLE;
        end
      end
      ssnt_pkg::S_INSFIND: begin
        if (stat.at_end || !stat.score_lt) state_next = ssnt_pkg::S_INSSHIFT;
      end
      ssnt_pkg::S_INSSHIFT: if (stat.at_ins) state_next = ssnt_pkg::S_INSWRITE;
      ssnt_pkg::S_INSWRITE: state_next = ssnt_pkg::S_IDLE;
      ssnt_pkg::S_SUFFIND: begin
        priority if (stat.at_end) state_next = ssnt_pkg::S_IDLE;
        else if (!stat.thr_lt) state_next = ssnt_pkg::S_SUFEMIT;
        else state_next = ssnt_pkg::S_SUFFIND;
      end
      ssnt_pkg::S_SUFEMIT: if (stat.ptr_last) state_next = ssnt_pkg::S_IDLE;
      ssnt_pkg::S_HEAVYRD: state_next = ssnt_pkg::S_HEAVYCMP;
      ssnt_pkg::S_HEAVYCMP: state_next = ssnt_pkg::S_IDLE;
      default: state_next = ssnt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = state != ssnt_pkg::S_IDLE;
    unique case (state)
      ssnt_pkg::S_IDLE: cmd.load = start;
      ssnt_pkg::S_DONE: begin
        cmd.scan_rst = 1'b1;
        // unknown opcode: one plain beat, table unchanged
        unique case (stat.op)
          ssnt_pkg::OP_UPSERT, ssnt_pkg::OP_REMOVE, ssnt_pkg::OP_LOOKUP,
          ssnt_pkg::OP_SUFFIX, ssnt_pkg::OP_HEAVY: ;
          default: begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_status = ssnt_pkg::ST_OK;
          end
        endcase
      end
      ssnt_pkg::S_FIND: begin
        priority if (stat.at_end) begin
          if (stat.op == ssnt_pkg::OP_UPSERT && !stat.full) begin
            cmd.scan_rst = 1'b1;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_status = (stat.op == ssnt_pkg::OP_UPSERT) ? ssnt_pkg::ST_FULL
                                                              : ssnt_pkg::ST_ABSENT;
          end
        end else if (stat.key_hit) begin
          if (stat.op == ssnt_pkg::OP_LOOKUP) begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_score = 1'b1;
            cmd.emit_status = ssnt_pkg::ST_OK;
          end else if (stat.ptr_last) begin
            cmd.cnt_dec = 1'b1;
            cmd.scan_rst = stat.op == ssnt_pkg::OP_UPSERT;
            cmd.emit = stat.op != ssnt_pkg::OP_UPSERT;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.shift_down = 1'b1;
            cmd.scan_inc = 1'b0;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ssnt_pkg::S_DELSHIFT: begin
        if (stat.ptr_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.scan_rst = 1'b1;
          cmd.emit = stat.op != ssnt_pkg::OP_UPSERT;
          cmd.emit_last = 1'b1;
        end else begin
          cmd.shift_down = 1'b1;
          cmd.scan_inc = 1'b1;
        end
      end
      ssnt_pkg::S_INSFIND: begin
        if (stat.at_end || !stat.score_lt) begin
          cmd.ins_mark = 1'b1;
          cmd.set_ptr_top = 1'b1;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      // move the tail up one slot until the insert position is reached
      ssnt_pkg::S_INSSHIFT: begin
        if (!stat.at_ins) begin
          cmd.shift_up = 1'b1;
          cmd.scan_dec = 1'b1;
        end
      end
      ssnt_pkg::S_INSWRITE: begin
        cmd.write_new = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_last = 1'b1;
      end
      ssnt_pkg::S_SUFFIND: begin
        priority if (stat.at_end) begin
          cmd.emit = 1'b1;
          cmd.emit_empty = 1'b1;
          cmd.emit_last = 1'b1;
        end else if (stat.thr_lt) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.scan_inc = 1'b0;
        end
      end
      ssnt_pkg::S_SUFEMIT: begin
        cmd.emit = 1'b1;
        cmd.emit_entry = 1'b1;
        cmd.emit_last = stat.ptr_last;
        cmd.scan_inc = 1'b1;
      end
      ssnt_pkg::S_HEAVYRD: cmd.heavy_rd = 1'b1;
      ssnt_pkg::S_HEAVYCMP: begin
        cmd.emit = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.emit_heavy = stat.heavy_ok && stat.thr_lt;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/sorted_score_neighbor_table_top.sv -----
// Channel  | Ports                                            | Beat marked by
// command  | opcode, key, score, threshold                    | start & !busy
// result   | out_key, out_score, status, heavy, count,        | result_valid
//          | empty_run, last                                  |
// Remove, lookup and suffix query scan the table once. A heavy test reads the
// entry at the heavy index, then compares it; an unknown opcode gives one plain beat.
// An upsert scans for the key, then for the insert point, and shifts the tail up.
// Each result beat is registered and appears in the cycle after the one that produced it.
// rst is synchronous; the table comes up empty.
// Results cannot be stalled; busy holds new commands off until done.
module sorted_score_neighbor_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ssnt_pkg::OpW-1:0]       opcode,
  input  logic [ssnt_pkg::KeyPortW-1:0]  key,
  input  logic [ssnt_pkg::ScoreW-1:0]    score,
  input  logic [ssnt_pkg::ScoreW-1:0]    threshold,
  output logic                           result_valid,
  output logic [ssnt_pkg::KeyPortW-1:0]  out_key,
  output logic [ssnt_pkg::ScoreW-1:0]    out_score,
  output logic [ssnt_pkg::StatusW-1:0]   status,
  output logic                           heavy,
  output logic [ssnt_pkg::CountW-1:0]    count,
  output logic                           empty_run,
  output logic                           last
);

  ssnt_pkg::cmd_t  cmd;
  ssnt_pkg::stat_t stat;

  ssnt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  ssnt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .opcode(opcode), .key(key), .score(score), .threshold(threshold),
    .out_key(out_key), .out_score(out_score), .status(status), .heavy(heavy),
    .count(count), .empty_run(empty_run), .last(last), .valid(result_valid)
  );

  // a command is never taken while one is in flight
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after command");
  // count never exceeds capacity
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (count <= ssnt_pkg::CountW'(ssnt_pkg::Capacity)))
    else $error("count beyond capacity");
  // an empty run result is always the last
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && empty_run) |-> last)
    else $error("empty run not last");

endmodule

// ----- bench/sorted_score_neighbor_table_top_tb.sv -----
module sorted_score_neighbor_table_top_tb;

  localparam int KW = ssnt_pkg::KeyPortW;
  localparam int SW = ssnt_pkg::ScoreW;
  localparam int STW = ssnt_pkg::StatusW;
  localparam int NW = ssnt_pkg::CountW;
  localparam int OW = ssnt_pkg::OpW;
  localparam int Cap = ssnt_pkg::Capacity;

  // one expected result beat
  typedef struct packed {
    logic [KW-1:0]  okey;
    logic [SW-1:0]  oscore;
    logic [STW-1:0] st;
    logic           hv;
    logic [NW-1:0]  cnt;
    logic           emp;
    logic           lst;
  } beat_t;

  // shadow table and queue of expected result beats
  class table_scoreboard;
    logic [KW-1:0] keys[Cap];
    logic [SW-1:0] scores[Cap];
    int unsigned   n;
    beat_t         pending[$];
    int            errors;

    function void add_beat(logic [KW-1:0] k, logic [SW-1:0] s,
                           logic [STW-1:0] st, logic hv, logic emp,
                           logic lst);
      beat_t b;
      b.okey = k; b.oscore = s; b.st = st; b.hv = hv;
      b.cnt = n[NW-1:0]; b.emp = emp; b.lst = lst;
      pending = {pending, b};
    endfunction

    function int find_pos(logic [KW-1:0] k);
      for (int i = 0; i < n; i++) if (keys[i] == k) return i;
      return n;
    endfunction

    function void drop_at(int p);
      for (int i = p; i + 1 < n; i++) begin
        keys[i] = keys[i+1];
        scores[i] = scores[i+1];
      end
      n--;
    endfunction

    // apply one accepted command beat to the shadow table
    function void note_command(logic [OW-1:0] op, logic [KW-1:0] k,
                               logic [SW-1:0] s, logic [SW-1:0] t);
      int p;
      longint unsigned c;
      logic hv;
      case (op)
        ssnt_pkg::OP_UPSERT: begin
          p = find_pos(k);
          if (p < n) drop_at(p);
          else if (n >= Cap) begin
            add_beat('0, '0, ssnt_pkg::ST_FULL, 0, 0, 1);
            return;
          end
          p = 0;
          while (p < n && scores[p] < s) p++;
          for (int i = n; i > p; i--) begin
            keys[i] = keys[i-1];
            scores[i] = scores[i-1];
          end
          keys[p] = k; scores[p] = s; n++;
          add_beat('0, '0, ssnt_pkg::ST_OK, 0, 0, 1);
        end
        ssnt_pkg::OP_REMOVE: begin
          p = find_pos(k);
          if (p < n) begin
            drop_at(p);
            add_beat('0, '0, ssnt_pkg::ST_OK, 0, 0, 1);
          end else add_beat('0, '0, ssnt_pkg::ST_ABSENT, 0, 0, 1);
        end
        ssnt_pkg::OP_SUFFIX: begin
          p = 0;
          while (p < n && scores[p] < t) p++;
          if (p >= n) add_beat('0, '0, ssnt_pkg::ST_OK, 0, 1, 1);
          else for (int i = p; i < n; i++)
            add_beat(keys[i], scores[i], ssnt_pkg::ST_OK, 0, 0, i + 1 == n);
        end
        ssnt_pkg::OP_HEAVY: begin
          hv = 0;
          if (n > 0) begin
            c = (longint'(t) * n + 65535) >> 16;
            if (c >= 1 && c - 1 < n && scores[c-1] < t) hv = 1;
          end
          add_beat('0, '0, ssnt_pkg::ST_OK, hv, 0, 1);
        end
        ssnt_pkg::OP_LOOKUP: begin
          p = find_pos(k);
          if (p < n) add_beat('0, scores[p], ssnt_pkg::ST_OK, 0, 0, 1);
          else add_beat('0, '0, ssnt_pkg::ST_ABSENT, 0, 0, 1);
        end
        default: add_beat('0, '0, ssnt_pkg::ST_OK, 0, 0, 1);
      endcase
    endfunction

    // compare one result beat against the oldest expectation
    function void check_result(beat_t got);
      beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.okey !== e.okey) begin
        $display("%0t: out_key exp %h got %h", $time, e.okey, got.okey); errors++;
      end
      if (got.oscore !== e.oscore) begin
        $display("%0t: out_score exp %h got %h", $time, e.oscore, got.oscore); errors++;
      end
      if (got.st !== e.st) begin
        $display("%0t: status exp %h got %h", $time, e.st, got.st); errors++;
      end
      if (got.hv !== e.hv) begin
        $display("%0t: heavy exp %h got %h", $time, e.hv, got.hv); errors++;
      end
      if (got.cnt !== e.cnt) begin
        $display("%0t: count exp %0d got %0d", $time, e.cnt, got.cnt); errors++;
      end
      if (got.emp !== e.emp) begin
        $display("%0t: empty_run exp %h got %h", $time, e.emp, got.emp); errors++;
      end
      if (got.lst !== e.lst) begin
        $display("%0t: last exp %h got %h", $time, e.lst, got.lst); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, result_valid, heavy, empty_run, last;
  logic [OW-1:0] opcode = '0;
  logic [KW-1:0] key = '0, out_key;
  logic [SW-1:0] score = '0, threshold = '0, out_score;
  logic [STW-1:0] status;
  logic [NW-1:0] count;

  table_scoreboard sb = new();
  logic [KW-1:0] key_pool[8];
  int unsigned cycles = 0;
  bit gaps_on = 1;

  sorted_score_neighbor_table_top uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // sample result beats and count cycles toward the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
    if (!rst && result_valid)
      sb.check_result({out_key, out_score, status, heavy, count, empty_run, last});
  end

  // issue one command beat; hold start until it is taken
  task send_cmd(logic [OW-1:0] op, logic [KW-1:0] k,
                logic [SW-1:0] s, logic [SW-1:0] t);
    start <= 1; opcode <= op; key <= k; score <= s; threshold <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, k, s, t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function logic [SW-1:0] rand_score();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return SW'($urandom_range(65530, 65536));
      default: return SW'($urandom_range(0, 65536));
    endcase
  endfunction

  function logic [KW-1:0] rand_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = '0; key_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, extremes, updates, unknown opcode
    send_cmd(ssnt_pkg::OP_SUFFIX, 0, 0, 0);
    send_cmd(ssnt_pkg::OP_HEAVY, 0, 0, 65536);
    send_cmd(ssnt_pkg::OP_LOOKUP, 5, 0, 0);
    send_cmd(ssnt_pkg::OP_REMOVE, 5, 0, 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 32'h0, 17'd0, 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 32'hFFFFFFFF, 17'h1FFFF, 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 32'h12345678, 17'd65536, 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 32'hA5A5A5A5, 17'd32768, 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 32'h5A5A5A5A, 17'd32768, 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 32'h12345678, 17'd100, 0);
    send_cmd(ssnt_pkg::OP_LOOKUP, 32'hFFFFFFFF, 0, 0);
    send_cmd(ssnt_pkg::OP_SUFFIX, 0, 0, 17'd32768);
    send_cmd(ssnt_pkg::OP_SUFFIX, 0, 0, 17'h1FFFF);
    send_cmd(ssnt_pkg::OP_HEAVY, 0, 0, 0);
    send_cmd(ssnt_pkg::OP_HEAVY, 0, 0, 17'd40000);
    send_cmd(ssnt_pkg::OP_HEAVY, 0, 0, 17'h1FFFF);
    send_cmd(ssnt_pkg::OP_REMOVE, 32'h0, 0, 0);
    send_cmd(3'd5, 1, 1, 1);
    send_cmd(3'd6, 0, 0, 0);
    send_cmd(3'd7, 32'hFFFFFFFF, 17'h1FFFF, 17'h1FFFF);
    // fill past capacity, then update a present key while full
    for (int i = 0; i < Cap + 2; i++) send_cmd(ssnt_pkg::OP_UPSERT, 1000 + i, rand_score(), 0);
    send_cmd(ssnt_pkg::OP_UPSERT, 1000, 17'd7, 0);
    send_cmd(ssnt_pkg::OP_SUFFIX, 0, 0, 0);

    // pause until all results are in
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_cmd(ssnt_pkg::OP_REMOVE, 1000 + i, 0, 0);

    // random phase; last part runs without gaps
    for (int i = 0; i < 390; i++) begin
      if (i > 330) gaps_on = 0;
      case ($urandom_range(0, 11))
        0, 1, 2, 3: send_cmd(ssnt_pkg::OP_UPSERT, rand_key(), rand_score(), 0);
        4, 5:       send_cmd(ssnt_pkg::OP_REMOVE, rand_key(), SW'($urandom), SW'($urandom));
        6:          send_cmd(ssnt_pkg::OP_SUFFIX, $urandom, SW'($urandom), rand_score());
        7, 8:       send_cmd(ssnt_pkg::OP_HEAVY, $urandom, SW'($urandom), rand_score());
        9, 10:      send_cmd(ssnt_pkg::OP_LOOKUP, rand_key(), SW'($urandom), SW'($urandom));
        default:    send_cmd(OW'($urandom_range(0, 7)), $urandom, SW'($urandom),
                             SW'($urandom));
      endcase
      if (i % 60 == 59) key_pool[$urandom_range(2, 7)] = $urandom;
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * Cap + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
